// ===== hdl/adcavg_pkg.sv =====
// Shared types and constants for the ADC averaging and auto-range sequencer.
package adcavg_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_AVG  = 2'd0,
        KIND_TEMP = 2'd1,
        KIND_KEY  = 2'd2
    } kind_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_GAIN_WIDE     = 3'd0;
    localparam logic [2:0] REG_OFFSET_WIDE   = 3'd1;
    localparam logic [2:0] REG_GAIN_NARROW   = 3'd2;
    localparam logic [2:0] REG_OFFSET_NARROW = 3'd3;
    localparam logic [2:0] REG_LOW_THRESH    = 3'd4;
    localparam logic [2:0] REG_HIGH_THRESH   = 3'd5;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int FIELD_W  = 12;
    localparam int GAIN_W   = 20;
    localparam int OFFSET_W = 12;
    localparam int MV_W     = 16;
    localparam int KEY_W    = 10;
    localparam int GAIN_FRAC = 16;

    // Register reset values: Q16 gains in mV per count, offsets in mV
    localparam logic [GAIN_W-1:0]   GAIN_WIDE_RST     = 20'd425087;
    localparam logic [OFFSET_W-1:0] OFFSET_WIDE_RST   = 12'd1118;
    localparam logic [GAIN_W-1:0]   GAIN_NARROW_RST   = 20'd125606;
    localparam logic [OFFSET_W-1:0] OFFSET_NARROW_RST = 12'd587;
    localparam logic [MV_W-1:0]     LOW_THRESH_RST    = 16'd5000;
    localparam logic [MV_W-1:0]     HIGH_THRESH_RST   = 16'd6000;

    localparam logic RANGE_WIDE   = 1'b0;
    localparam logic RANGE_NARROW = 1'b1;

endpackage

// ===== hdl/adc_average_autorange_sequencer.sv =====
// ADC averaging, millivolt conversion and auto-range sequencer with APB registers.
// A result is registered: out_valid rises in the cycle after the transaction that causes it.
// Throughput: one input transaction per cycle; result ticks wait while a result is unread.
// A cycle is SAMPLES accumulate ticks (no result), an average, a temperature and a key tick.
// The average divide is a reciprocal multiply done as each sample is summed.
// rst_n (async, active low) clears phase, sums, range (wide) and loads register defaults.
module adc_average_autorange_sequencer #(
    parameter int SAMPLES  = 16,
    parameter int ADC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adcavg_pkg::PADDR_W-1:0]       paddr,
    input  logic [adcavg_pkg::PDATA_W-1:0]       pwdata,
    output logic [adcavg_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [adcavg_pkg::FIELD_W-1:0]       adc_volt,
    input  logic [adcavg_pkg::FIELD_W-1:0]       adc_curr,
    input  logic [adcavg_pkg::FIELD_W-1:0]       adc_temp,
    input  logic [adcavg_pkg::FIELD_W-1:0]       adc_keys,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           kind,
    output logic [adcavg_pkg::FIELD_W-1:0]       avg_curr,
    output logic [adcavg_pkg::FIELD_W-1:0]       avg_volt,
    output logic [adcavg_pkg::MV_W-1:0]          volt_mv,
    output logic                                 range_sel,
    output logic                                 range_changed,
    output logic [adcavg_pkg::FIELD_W-1:0]       temp_raw,
    output logic [adcavg_pkg::KEY_W-1:0]         key_code
);

    localparam int DATA_W    = (ADC_BITS < adcavg_pkg::FIELD_W) ? ADC_BITS
                                                                 : adcavg_pkg::FIELD_W;
    localparam int SAMP_LOG  = $clog2(SAMPLES);
    localparam int SUM_W     = DATA_W + SAMP_LOG;
    localparam int PH_W      = $clog2(SAMPLES + 3);
    // floor(sum / SAMPLES) == (sum * DIV_MUL) >> DIV_SHIFT for every reachable sum
    localparam int DIV_SHIFT = SUM_W + SAMP_LOG;
    localparam int DIV_MUL_W = SUM_W + 1;
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'((DIV_ONE + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam int PROD_W    = SUM_W + DIV_MUL_W;
    localparam int MVP_W     = DATA_W + adcavg_pkg::GAIN_W;
    localparam int MVS_W     = adcavg_pkg::MV_W + 1;

    localparam logic [PH_W-1:0] PH_CALC = PH_W'(SAMPLES);
    localparam logic [PH_W-1:0] PH_TEMP = PH_W'(SAMPLES + 1);
    localparam logic [PH_W-1:0] PH_ONE  = PH_W'(1);
    localparam logic [MVS_W-1:0] MV_MAX = {1'b0, {adcavg_pkg::MV_W{1'b1}}};

    // configuration registers
    logic [adcavg_pkg::GAIN_W-1:0]   gain_wide_reg, gain_narrow_reg;
    logic [adcavg_pkg::OFFSET_W-1:0] offset_wide_reg, offset_narrow_reg;
    logic [adcavg_pkg::MV_W-1:0]     low_thresh_reg, high_thresh_reg;

    logic [2:0] reg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_wide_reg     <= adcavg_pkg::GAIN_WIDE_RST;
            offset_wide_reg   <= adcavg_pkg::OFFSET_WIDE_RST;
            gain_narrow_reg   <= adcavg_pkg::GAIN_NARROW_RST;
            offset_narrow_reg <= adcavg_pkg::OFFSET_NARROW_RST;
            low_thresh_reg    <= adcavg_pkg::LOW_THRESH_RST;
            high_thresh_reg   <= adcavg_pkg::HIGH_THRESH_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                adcavg_pkg::REG_GAIN_WIDE:
                    gain_wide_reg <= pwdata[adcavg_pkg::GAIN_W-1:0];
                adcavg_pkg::REG_OFFSET_WIDE:
                    offset_wide_reg <= pwdata[adcavg_pkg::OFFSET_W-1:0];
                adcavg_pkg::REG_GAIN_NARROW:
                    gain_narrow_reg <= pwdata[adcavg_pkg::GAIN_W-1:0];
                adcavg_pkg::REG_OFFSET_NARROW:
                    offset_narrow_reg <= pwdata[adcavg_pkg::OFFSET_W-1:0];
                adcavg_pkg::REG_LOW_THRESH:
                    low_thresh_reg <= pwdata[adcavg_pkg::MV_W-1:0];
                adcavg_pkg::REG_HIGH_THRESH:
                    high_thresh_reg <= pwdata[adcavg_pkg::MV_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            adcavg_pkg::REG_GAIN_WIDE:
                prdata = adcavg_pkg::PDATA_W'(gain_wide_reg);
            adcavg_pkg::REG_OFFSET_WIDE:
                prdata = adcavg_pkg::PDATA_W'(offset_wide_reg);
            adcavg_pkg::REG_GAIN_NARROW:
                prdata = adcavg_pkg::PDATA_W'(gain_narrow_reg);
            adcavg_pkg::REG_OFFSET_NARROW:
                prdata = adcavg_pkg::PDATA_W'(offset_narrow_reg);
            adcavg_pkg::REG_LOW_THRESH:
                prdata = adcavg_pkg::PDATA_W'(low_thresh_reg);
            adcavg_pkg::REG_HIGH_THRESH:
                prdata = adcavg_pkg::PDATA_W'(high_thresh_reg);
            default:
                prdata = '0;
        endcase
    end

    // sequencer state
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [SUM_W-1:0]  sum_volt_reg, sum_volt_next;
    logic [SUM_W-1:0]  sum_curr_reg, sum_curr_next;
    logic [DATA_W-1:0] avg_volt_reg, avg_volt_next;
    logic [DATA_W-1:0] avg_curr_reg, avg_curr_next;
    logic              range_reg, range_next;

    // result register
    adcavg_pkg::kind_t           kind_reg, kind_next;
    logic                        out_valid_reg, out_valid_next;
    logic [adcavg_pkg::FIELD_W-1:0] avg_curr_out_reg, avg_curr_out_next;
    logic [adcavg_pkg::FIELD_W-1:0] avg_volt_out_reg, avg_volt_out_next;
    logic [adcavg_pkg::MV_W-1:0] volt_mv_reg, volt_mv_next;
    logic                        range_sel_reg, range_sel_next;
    logic                        range_changed_reg, range_changed_next;
    logic [adcavg_pkg::FIELD_W-1:0] temp_raw_reg, temp_raw_next;
    logic [adcavg_pkg::KEY_W-1:0] key_code_reg, key_code_next;

    logic              in_fire, out_fire, accum_tick;
    logic [DATA_W-1:0] volt_m, curr_m, temp_m, keys_m;
    logic [PROD_W-1:0] div_volt_prod, div_curr_prod;
    logic [adcavg_pkg::GAIN_W-1:0]   gain_sel;
    logic [adcavg_pkg::OFFSET_W-1:0] offset_sel;
    logic [MVP_W-1:0]  mv_prod;
    logic [MVS_W-1:0]  mv_full;
    logic [adcavg_pkg::MV_W-1:0] mv_sat;
    logic              switch_range;

    assign accum_tick = (phase_reg < PH_CALC);
    // accumulate ticks never produce a result, so they pass even when the output stalls
    assign in_ready   = accum_tick || !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid_reg && out_ready;

    assign volt_m = adc_volt[DATA_W-1:0];
    assign curr_m = adc_curr[DATA_W-1:0];
    assign temp_m = adc_temp[DATA_W-1:0];
    assign keys_m = adc_keys[DATA_W-1:0];

    assign sum_volt_next = sum_volt_reg + SUM_W'(volt_m);
    assign sum_curr_next = sum_curr_reg + SUM_W'(curr_m);
    assign div_volt_prod = PROD_W'(sum_volt_next) * PROD_W'(DIV_MUL);
    assign div_curr_prod = PROD_W'(sum_curr_next) * PROD_W'(DIV_MUL);
    assign avg_volt_next = div_volt_prod[DIV_SHIFT +: DATA_W];
    assign avg_curr_next = div_curr_prod[DIV_SHIFT +: DATA_W];

    // millivolt conversion with the range active before the decision
    assign gain_sel   = (range_reg == adcavg_pkg::RANGE_NARROW) ? gain_narrow_reg
                                                                 : gain_wide_reg;
    assign offset_sel = (range_reg == adcavg_pkg::RANGE_NARROW) ? offset_narrow_reg
                                                                 : offset_wide_reg;
    assign mv_prod = MVP_W'(avg_volt_reg) * MVP_W'(gain_sel);
    assign mv_full = MVS_W'(mv_prod >> adcavg_pkg::GAIN_FRAC) + MVS_W'(offset_sel);
    assign mv_sat  = (mv_full > MV_MAX) ? {adcavg_pkg::MV_W{1'b1}}
                                        : mv_full[adcavg_pkg::MV_W-1:0];
    assign switch_range = (range_reg == adcavg_pkg::RANGE_NARROW)
                          ? (mv_sat >= high_thresh_reg)
                          : (mv_sat <= low_thresh_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        range_next         = range_reg;
        out_valid_next     = out_valid_reg;
        kind_next          = kind_reg;
        avg_curr_out_next  = '0;
        avg_volt_out_next  = '0;
        volt_mv_next       = '0;
        range_sel_next     = 1'b0;
        range_changed_next = 1'b0;
        temp_raw_next      = '0;
        key_code_next      = '0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            if (accum_tick)
            begin
                phase_next = phase_reg + PH_ONE;
            end
            else if (phase_reg == PH_CALC)
            begin
                phase_next         = phase_reg + PH_ONE;
                range_next         = switch_range ? ~range_reg : range_reg;
                out_valid_next     = 1'b1;
                kind_next          = adcavg_pkg::KIND_AVG;
                avg_curr_out_next  = adcavg_pkg::FIELD_W'(avg_curr_reg);
                avg_volt_out_next  = adcavg_pkg::FIELD_W'(avg_volt_reg);
                volt_mv_next       = mv_sat;
                range_sel_next     = switch_range ? ~range_reg : range_reg;
                range_changed_next = switch_range;
            end
            else if (phase_reg == PH_TEMP)
            begin
                phase_next     = phase_reg + PH_ONE;
                out_valid_next = 1'b1;
                kind_next      = adcavg_pkg::KIND_TEMP;
                temp_raw_next  = adcavg_pkg::FIELD_W'(temp_m);
            end
            else
            begin
                phase_next     = '0;
                out_valid_next = 1'b1;
                kind_next      = adcavg_pkg::KIND_KEY;
                key_code_next  = adcavg_pkg::KEY_W'(adcavg_pkg::FIELD_W'(keys_m) >> 2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            sum_volt_reg  <= '0;
            sum_curr_reg  <= '0;
            range_reg     <= adcavg_pkg::RANGE_WIDE;
            out_valid_reg <= 1'b0;
            kind_reg      <= adcavg_pkg::KIND_AVG;
        end
        else
        begin
            phase_reg     <= phase_next;
            range_reg     <= range_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            if (in_fire)
            begin
                if (accum_tick)
                begin
                    sum_volt_reg <= sum_volt_next;
                    sum_curr_reg <= sum_curr_next;
                end
                else if (phase_reg == PH_CALC)
                begin
                    sum_volt_reg <= '0;
                    sum_curr_reg <= '0;
                end
            end
        end
    end

    // payload registers: averages track the running sums, result loads with a transaction
    always_ff @(posedge clk)
    begin
        if (in_fire && accum_tick)
        begin
            avg_volt_reg <= avg_volt_next;
            avg_curr_reg <= avg_curr_next;
        end
        if (in_fire && !accum_tick)
        begin
            avg_curr_out_reg  <= avg_curr_out_next;
            avg_volt_out_reg  <= avg_volt_out_next;
            volt_mv_reg       <= volt_mv_next;
            range_sel_reg     <= range_sel_next;
            range_changed_reg <= range_changed_next;
            temp_raw_reg      <= temp_raw_next;
            key_code_reg      <= key_code_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign avg_curr      = avg_curr_out_reg;
    assign avg_volt      = avg_volt_out_reg;
    assign volt_mv       = volt_mv_reg;
    assign range_sel     = range_sel_reg;
    assign range_changed = range_changed_reg;
    assign temp_raw      = temp_raw_reg;
    assign key_code      = key_code_reg;

    // phase never runs past the key tick
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_TEMP + PH_ONE)
        else $error("phase out of range");

    // the average tick always yields an average result
    a_calc_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_CALC |=> out_valid_reg && kind_reg == adcavg_pkg::KIND_AVG)
        else $error("average tick lost its result");

    // an accumulate tick on an empty output creates no result
    a_accum_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && accum_tick && !out_valid_reg |=> !out_valid_reg)
        else $error("accumulate tick produced a result");

    // range state only moves on the average tick
    a_range_move: assert property (@(posedge clk) disable iff (!rst_n)
        range_reg != $past(range_reg) |-> $past(in_fire) && $past(phase_reg) == PH_CALC)
        else $error("range changed outside the average tick");

endmodule
